/* hw/rtl/mrc_pkg.sv */
// Shared types, constants and a helper function for the majority-rule consensus counter.
`timescale 1ns / 1ps

package mrc_pkg;

   // Node slots carried through the datapath (upper bound of the node count)
   localparam int NODE_SLOTS = 8;
   localparam int ADJ_WIDTH  = 64;
   localparam int NCNT_WIDTH = 4;
   localparam int STEP_WIDTH = 8;
   localparam int CNT_WIDTH  = 9;
   localparam int DATA_WIDTH = 32;
   localparam int ADDR_WIDTH = 3;

   // Register reset values
   localparam logic [STEP_WIDTH-1:0] STEP_LIMIT_RESET = 8'd100;

   // Register indexes (decoded from the word address)
   localparam logic REG_NODE_COUNT = 1'b0;
   localparam logic REG_STEP_LIMIT = 1'b1;

   typedef logic [NODE_SLOTS-1:0] node_vec_type;
   typedef logic [CNT_WIDTH-1:0]  count_type;

   // One classified request handed from the front end to the engine
   typedef struct packed {
      node_vec_type [NODE_SLOTS-1:0]       masks;   // in-neighbor mask per node
      logic [NODE_SLOTS-1:0][NCNT_WIDTH-1:0] totals; // in-degree per node
      logic [NCNT_WIDTH-1:0]               n;       // nodes in use, 1..max
      node_vec_type                        all;     // all-ones over used nodes
      logic [STEP_WIDTH-1:0]               limit;   // step limit, at least 1
   } job_type;

   // Population count of one node vector
   function automatic logic [NCNT_WIDTH-1:0] ones_in(input node_vec_type v);
      logic [NCNT_WIDTH-1:0] c;
      c = '0;
      for (int b = 0; b < NODE_SLOTS; b++) begin
         c = c + {{(NCNT_WIDTH-1){1'b0}}, v[b]};
      end
      return c;
   endfunction

endpackage

/* hw/rtl/mrc_fifo.sv */
// Small register FIFO used for the job queue and the response queue.
`timescale 1ns / 1ps

module mrc_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PTR_WIDTH = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int LVL_WIDTH = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]     mem_ff [DEPTH];
   logic [PTR_WIDTH-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_WIDTH-1:0] rd_ptr_ff, rd_ptr_in;
   logic [LVL_WIDTH-1:0] level_ff, level_in;
   logic                 do_push, do_pop;

   assign full     = (level_ff == LVL_WIDTH'(DEPTH));
   assign empty    = (level_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   // Pointer and fill level update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      level_in  = level_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_WIDTH'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_WIDTH'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         level_in = level_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         level_in = level_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* hw/rtl/mrc_front.sv */
// Front end: configuration registers and classification of each incoming graph.
`timescale 1ns / 1ps

module mrc_front #(
   parameter int MAX_NODES = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   // configuration port
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [mrc_pkg::ADDR_WIDTH-1:0]      paddr,
   input  logic [mrc_pkg::DATA_WIDTH-1:0]      pwdata,
   output logic [mrc_pkg::DATA_WIDTH-1:0]      prdata,
   // incoming graph
   input  logic [mrc_pkg::ADJ_WIDTH-1:0]       adjacency,
   output mrc_pkg::job_type                    job
);

   logic [mrc_pkg::NCNT_WIDTH-1:0] node_count_ff, node_count_in;
   logic [mrc_pkg::STEP_WIDTH-1:0] step_limit_ff, step_limit_in;
   logic                           reg_write;
   logic                           reg_sel;
   logic [mrc_pkg::NCNT_WIDTH-1:0] n_eff;
   mrc_pkg::node_vec_type          used;

   assign reg_write = psel && penable && pwrite;
   assign reg_sel   = paddr[2];

   // Register writes
   always_comb begin
      node_count_in = node_count_ff;
      step_limit_in = step_limit_ff;
      if (reg_write) begin
         case (reg_sel)
            mrc_pkg::REG_NODE_COUNT: node_count_in = pwdata[mrc_pkg::NCNT_WIDTH-1:0];
            mrc_pkg::REG_STEP_LIMIT: step_limit_in = pwdata[mrc_pkg::STEP_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= mrc_pkg::NCNT_WIDTH'(MAX_NODES);
         step_limit_ff <= mrc_pkg::STEP_LIMIT_RESET;
      end else begin
         node_count_ff <= node_count_in;
         step_limit_ff <= step_limit_in;
      end
   end

   // Register readback
   always_comb begin
      case (reg_sel)
         mrc_pkg::REG_NODE_COUNT:
            prdata = {{(mrc_pkg::DATA_WIDTH-mrc_pkg::NCNT_WIDTH){1'b0}}, node_count_ff};
         mrc_pkg::REG_STEP_LIMIT:
            prdata = {{(mrc_pkg::DATA_WIDTH-mrc_pkg::STEP_WIDTH){1'b0}}, step_limit_ff};
         default: prdata = '0;
      endcase
   end

   // Clamp node count to 1..MAX_NODES
   always_comb begin
      if (node_count_ff == '0) begin
         n_eff = mrc_pkg::NCNT_WIDTH'(1);
      end else if (node_count_ff > mrc_pkg::NCNT_WIDTH'(MAX_NODES)) begin
         n_eff = mrc_pkg::NCNT_WIDTH'(MAX_NODES);
      end else begin
         n_eff = node_count_ff;
      end
   end

   // Mask of nodes in use
   always_comb begin
      for (int i = 0; i < mrc_pkg::NODE_SLOTS; i++) begin
         used[i] = (mrc_pkg::NCNT_WIDTH'(i) < n_eff);
      end
   end

   // In-neighbor masks: edge src->dst sits at bit src*MAX_NODES+dst
   for (genvar gi = 0; gi < mrc_pkg::NODE_SLOTS; gi++) begin : g_dst
      for (genvar gj = 0; gj < mrc_pkg::NODE_SLOTS; gj++) begin : g_src
         localparam int POS = (gj * MAX_NODES + gi) % mrc_pkg::ADJ_WIDTH;
         assign job.masks[gi][gj] = adjacency[POS] && used[gi] && used[gj];
      end
      assign job.totals[gi] = mrc_pkg::ones_in(job.masks[gi]);
   end

   assign job.n     = n_eff;
   assign job.all   = used;
   assign job.limit = (step_limit_ff == '0) ? mrc_pkg::STEP_WIDTH'(1) : step_limit_ff;

endmodule

/* hw/rtl/mrc_engine.sv */
// Back end: walks every start state, iterates majority updates and counts consensus runs.
`timescale 1ns / 1ps

module mrc_engine (
   input  logic                 clock,
   input  logic                 reset,
   input  mrc_pkg::job_type     job,
   input  logic                 job_empty,
   output logic                 job_pop,
   input  logic                 rsp_full,
   output logic                 rsp_push,
   output mrc_pkg::count_type   rsp_count
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DONE
   } state_type;

   state_type                      state_ff, state_in;
   mrc_pkg::job_type               job_ff, job_in;
   mrc_pkg::node_vec_type          cur_ff, cur_in;
   mrc_pkg::node_vec_type          init_ff, init_in;
   logic [mrc_pkg::STEP_WIDTH-1:0] step_ff, step_in;
   mrc_pkg::count_type             count_ff, count_in;

   mrc_pkg::node_vec_type          nxt;
   logic                           run_done;
   logic                           major;
   logic                           hit;
   logic [mrc_pkg::NCNT_WIDTH:0]   init_twice;

   // One synchronous update of all nodes
   always_comb begin
      logic [mrc_pkg::NCNT_WIDTH:0] twice;
      logic [mrc_pkg::NCNT_WIDTH:0] total;
      for (int i = 0; i < mrc_pkg::NODE_SLOTS; i++) begin
         twice = {mrc_pkg::ones_in(job_ff.masks[i] & cur_ff), 1'b0};
         total = {1'b0, job_ff.totals[i]};
         nxt[i] = cur_ff[i];
         if (total != '0) begin
            if (twice > total) begin
               nxt[i] = 1'b1;
            end else if (twice < total) begin
               nxt[i] = 1'b0;
            end
         end
      end
   end

   // Initial majority, node 0 breaks a tie
   assign init_twice = {mrc_pkg::ones_in(init_ff), 1'b0};
   always_comb begin
      if (init_twice > {1'b0, job_ff.n}) begin
         major = 1'b1;
      end else if (init_twice < {1'b0, job_ff.n}) begin
         major = 1'b0;
      end else begin
         major = init_ff[0];
      end
   end

   assign run_done = (nxt == cur_ff) || (step_ff == job_ff.limit - 1'b1);
   assign hit      = major ? (nxt == job_ff.all) : (nxt == '0);

   // Sequencer
   always_comb begin
      state_in = state_ff;
      job_in   = job_ff;
      cur_in   = cur_ff;
      init_in  = init_ff;
      step_in  = step_ff;
      count_in = count_ff;
      job_pop  = 1'b0;
      rsp_push = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (!job_empty) begin
               job_pop  = 1'b1;
               job_in   = job;
               cur_in   = '0;
               init_in  = '0;
               step_in  = '0;
               count_in = '0;
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (run_done) begin
               count_in = count_ff + mrc_pkg::CNT_WIDTH'(hit);
               step_in  = '0;
               if (init_ff == job_ff.all) begin
                  state_in = ST_DONE;
               end else begin
                  init_in = init_ff + 1'b1;
                  cur_in  = init_ff + 1'b1;
               end
            end else begin
               cur_in  = nxt;
               step_in = step_ff + 1'b1;
            end
         end
         ST_DONE: begin
            if (!rsp_full) begin
               rsp_push = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_count = count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      job_ff   <= job_in;
      cur_ff   <= cur_in;
      init_ff  <= init_in;
      step_ff  <= step_in;
      count_ff <= count_in;
   end

   // Step counter never reaches the limit inside a run
   a_step_below_limit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |-> (step_ff < job_ff.limit))
      else $error("step counter at or above step limit");

   // Unused nodes stay zero during a run
   a_unused_nodes_zero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |-> ((cur_ff & ~job_ff.all) == '0))
      else $error("unused node took a nonzero value");

   // Count never exceeds the number of start states
   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      rsp_push |-> (count_ff <= ({1'b0, job_ff.all} + 1'b1)))
      else $error("consensus count exceeds start states");

   // A new job is taken only when idle
   a_pop_when_idle: assert property (@(posedge clock) disable iff (reset)
      job_pop |=> (state_ff == ST_RUN))
      else $error("job popped without starting a run");

endmodule

/* hw/rtl/majority_rule_consensus_counter.sv */
// Majority-rule consensus counter: top level tying front end, job queue, engine and response queue.
// The engine handles one request at a time: it walks all 2^n start states, each run ending
// when the state settles or the step limit is reached, and takes the next job only after
// its count is queued. One update of all nodes per cycle while a run is in progress.
// Two-entry job and response queues decouple front end and engine.
// Synchronous active-high reset clears control state; node_count resets to MAX_NODES,
// step_limit to 100.
`timescale 1ns / 1ps

module majority_rule_consensus_counter #(
   parameter int MAX_NODES = 8
) (
   input  logic                           clock,
   input  logic                           reset,
   // request channel
   input  logic                           push,
   output logic                           full,
   input  logic [mrc_pkg::ADJ_WIDTH-1:0]  req_adjacency,
   // response channel
   output logic                           empty,
   input  logic                           pop,
   output logic [mrc_pkg::CNT_WIDTH-1:0]  rsp_converging_count,
   // configuration port
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [mrc_pkg::ADDR_WIDTH-1:0] paddr,
   input  logic [mrc_pkg::DATA_WIDTH-1:0] pwdata,
   output logic [mrc_pkg::DATA_WIDTH-1:0] prdata,
   output logic                           pready
);

   localparam int JOB_WIDTH = $bits(mrc_pkg::job_type);

   mrc_pkg::job_type   front_job;
   mrc_pkg::job_type   queued_job;
   logic               job_empty;
   logic               job_pop;
   logic               rsp_full;
   logic               rsp_push;
   mrc_pkg::count_type rsp_count;

   assign pready = 1'b1;

   // Configuration and request classification
   mrc_front #(
      .MAX_NODES (MAX_NODES)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .adjacency (req_adjacency),
      .job       (front_job)
   );

   // Job queue between front end and engine
   mrc_fifo #(
      .WIDTH (JOB_WIDTH),
      .DEPTH (2)
   ) u_job_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (front_job),
      .full      (full),
      .pop       (job_pop),
      .pop_data  (queued_job),
      .empty     (job_empty)
   );

   // Consensus engine
   mrc_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .job       (queued_job),
      .job_empty (job_empty),
      .job_pop   (job_pop),
      .rsp_full  (rsp_full),
      .rsp_push  (rsp_push),
      .rsp_count (rsp_count)
   );

   // Response queue
   mrc_fifo #(
      .WIDTH (mrc_pkg::CNT_WIDTH),
      .DEPTH (2)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (rsp_count),
      .full      (rsp_full),
      .pop       (pop),
      .pop_data  (rsp_converging_count),
      .empty     (empty)
   );

endmodule

/* bench/tb_top.sv */
// Self-checking bench for the majority-rule consensus counter: queued stimulus, predictor, scoreboard.
`timescale 1ns / 1ps

module tb_top;

   // What the driver can be asked to do next
   typedef enum logic [1:0] {
      STIM_REQUEST,   // push one adjacency request
      STIM_CSR,       // write one register, only while the block is idle
      STIM_DRAIN,     // hold off until every expected count has come back
      STIM_PACE       // change the idle rates of sender and receiver
   } stim_kind_type;

   typedef struct {
      stim_kind_type                  kind;
      logic [mrc_pkg::ADJ_WIDTH-1:0]  data;
      logic [mrc_pkg::ADDR_WIDTH-1:0] addr;
      int                             send_pct;
      int                             recv_pct;
   } stim_entry_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           push = 1'b0;
   logic                           full;
   logic [mrc_pkg::ADJ_WIDTH-1:0]  req_adjacency = '0;
   logic                           empty;
   logic                           pop = 1'b0;
   mrc_pkg::count_type             rsp_converging_count;
   logic                           psel = 1'b0;
   logic                           penable = 1'b0;
   logic                           pwrite = 1'b0;
   logic [mrc_pkg::ADDR_WIDTH-1:0] paddr = '0;
   logic [mrc_pkg::DATA_WIDTH-1:0] pwdata = '0;
   logic [mrc_pkg::DATA_WIDTH-1:0] prdata;
   logic                           pready;

   stim_entry_type                 stim_queue[$];
   mrc_pkg::count_type             expected_counts[$];

   // Register copies used by the predictor
   logic [mrc_pkg::NCNT_WIDTH-1:0] model_node_count = mrc_pkg::NCNT_WIDTH'(mrc_pkg::NODE_SLOTS);
   logic [mrc_pkg::STEP_WIDTH-1:0] model_step_limit = mrc_pkg::STEP_LIMIT_RESET;

   int                    send_idle_pct = 0;
   int                    recv_idle_pct = 0;
   int                    requests_accepted = 0;
   int                    results_retired = 0;
   int                    fail_count = 0;

   // Worst-case cycle estimate, built while the stimulus is queued
   int                    plan_nodes = mrc_pkg::NODE_SLOTS;
   int                    plan_limit = 100;
   longint                cycle_budget = 0;
   longint                cycle_limit = 64'd10_000_000;
   longint                cycle_count = 0;

   majority_rule_consensus_counter u_dut (
      .clock                (clock),
      .reset                (reset),
      .push                 (push),
      .full                 (full),
      .req_adjacency        (req_adjacency),
      .empty                (empty),
      .pop                  (pop),
      .rsp_converging_count (rsp_converging_count),
      .psel                 (psel),
      .penable              (penable),
      .pwrite               (pwrite),
      .paddr                (paddr),
      .pwdata               (pwdata),
      .prdata               (prdata),
      .pready               (pready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Count of start states whose run ends in consensus on the initial majority
   function automatic mrc_pkg::count_type count_consensus(
         input logic [mrc_pkg::ADJ_WIDTH-1:0]  graph,
         input logic [mrc_pkg::NCNT_WIDTH-1:0] nodes_cfg,
         input logic [mrc_pkg::STEP_WIDTH-1:0] limit_cfg);
      mrc_pkg::node_vec_type in_from [mrc_pkg::NODE_SLOTS];
      mrc_pkg::node_vec_type all_set, start_vals, cur, nxt;
      int           nodes, limit, ones, total, agree, tally;
      int           k, t, i, j, b;
      logic         majority, settled, node_val;
      // zero node count reads as one, oversize saturates; zero step limit reads as one
      nodes = (nodes_cfg == 0) ? 1 :
              ((nodes_cfg > mrc_pkg::NODE_SLOTS) ? mrc_pkg::NODE_SLOTS : int'(nodes_cfg));
      limit = (limit_cfg == 0) ? 1 : int'(limit_cfg);
      // in-neighbor masks over the used nodes only; self-loops count
      for (i = 0; i < mrc_pkg::NODE_SLOTS; i++) begin
         in_from[i] = '0;
         for (j = 0; j < mrc_pkg::NODE_SLOTS; j++) begin
            if (i < nodes && j < nodes && graph[j*mrc_pkg::NODE_SLOTS+i])
               in_from[i][j] = 1'b1;
         end
      end
      all_set = mrc_pkg::node_vec_type'((1 << nodes) - 1);
      tally = 0;
      for (k = 0; k < (1 << nodes); k++) begin
         // node 0 takes the most significant bit of the start index
         start_vals = '0;
         for (i = 0; i < nodes; i++)
            start_vals[i] = k[nodes-1-i];
         cur = start_vals;
         nxt = start_vals;
         settled = 1'b0;
         for (t = 0; t < limit && !settled; t++) begin
            nxt = '0;
            for (i = 0; i < nodes; i++) begin
               total = 0;
               agree = 0;
               for (b = 0; b < mrc_pkg::NODE_SLOTS; b++) begin
                  total += in_from[i][b];
                  agree += in_from[i][b] & cur[b];
               end
               // keep own value on a tie or with no in-neighbors
               node_val = cur[i];
               if (total != 0) begin
                  if (2 * agree > total) node_val = 1'b1;
                  else if (2 * agree < total) node_val = 1'b0;
               end
               nxt[i] = node_val;
            end
            if (nxt == cur) settled = 1'b1;
            else cur = nxt;
         end
         ones = 0;
         for (i = 0; i < mrc_pkg::NODE_SLOTS; i++)
            ones += start_vals[i];
         // tied start state: node 0 decides
         if (2 * ones > nodes) majority = 1'b1;
         else if (2 * ones < nodes) majority = 1'b0;
         else majority = start_vals[0];
         if ((nxt == all_set && majority) || (nxt == '0 && !majority))
            tally++;
      end
      return mrc_pkg::count_type'(tally);
   endfunction

   task automatic queue_request(input logic [mrc_pkg::ADJ_WIDTH-1:0] adj);
      stim_entry_type e;
      e.kind = STIM_REQUEST;
      e.data = adj;
      e.addr = '0;
      e.send_pct = 0;
      e.recv_pct = 0;
      stim_queue.push_back(e);
      cycle_budget += (longint'(1) << plan_nodes) * plan_limit + 64;
   endtask

   // Both registers, with junk above the register width
   task automatic queue_config(input int n_raw, input int lim_raw);
      stim_entry_type e;
      e.kind = STIM_CSR;
      e.send_pct = 0;
      e.recv_pct = 0;
      e.addr = {mrc_pkg::REG_NODE_COUNT, 2'b00};
      e.data = {32'd0, ($urandom() & 32'hFFFF_FFF0) | (n_raw & 32'hF)};
      stim_queue.push_back(e);
      e.addr = {mrc_pkg::REG_STEP_LIMIT, 2'b00};
      e.data = {32'd0, ($urandom() & 32'hFFFF_FF00) | (lim_raw & 32'hFF)};
      stim_queue.push_back(e);
      plan_nodes = (n_raw == 0) ? 1 :
                   ((n_raw > mrc_pkg::NODE_SLOTS) ? mrc_pkg::NODE_SLOTS : n_raw);
      plan_limit = (lim_raw == 0) ? 1 : lim_raw;
      cycle_budget += 200;
   endtask

   task automatic queue_control(input stim_kind_type kind, input int s_pct, input int r_pct);
      stim_entry_type e;
      e.kind = kind;
      e.data = '0;
      e.addr = '0;
      e.send_pct = s_pct;
      e.recv_pct = r_pct;
      stim_queue.push_back(e);
   endtask

   // Driver: request channel and register writes
   always @(posedge clock) begin : driver
      stim_entry_type head;
      logic           req_taken;
      logic           next_push;
      int             outstanding;
      if (reset) begin
         push <= 1'b0;
         psel <= 1'b0;
         penable <= 1'b0;
         pwrite <= 1'b0;
      end else begin
         req_taken = push && !full;
         if (req_taken) begin
            expected_counts.push_back(count_consensus(req_adjacency, model_node_count,
                                                      model_step_limit));
            requests_accepted = requests_accepted + 1;
         end
         next_push = push && !req_taken;
         outstanding = requests_accepted - results_retired;
         if (psel && penable) begin
            // access phase; register lands when pready is high
            if (pready) begin
               if (paddr[2] == mrc_pkg::REG_NODE_COUNT)
                  model_node_count = pwdata[mrc_pkg::NCNT_WIDTH-1:0];
               else model_step_limit = pwdata[mrc_pkg::STEP_WIDTH-1:0];
               psel <= 1'b0;
               penable <= 1'b0;
            end
         end else if (psel) begin
            penable <= 1'b1;
         end else if (!next_push && stim_queue.size() != 0) begin
            head = stim_queue[0];
            case (head.kind)
               STIM_REQUEST: begin
                  if ($urandom_range(99) >= send_idle_pct) begin
                     next_push = 1'b1;
                     req_adjacency <= head.data;
                     void'(stim_queue.pop_front());
                  end
               end
               STIM_CSR: begin
                  if (outstanding == 0) begin
                     psel <= 1'b1;
                     penable <= 1'b0;
                     pwrite <= 1'b1;
                     paddr <= head.addr;
                     pwdata <= head.data[mrc_pkg::DATA_WIDTH-1:0];
                     void'(stim_queue.pop_front());
                  end
               end
               STIM_DRAIN: begin
                  if (outstanding == 0) void'(stim_queue.pop_front());
               end
               STIM_PACE: begin
                  send_idle_pct <= head.send_pct;
                  recv_idle_pct <= head.recv_pct;
                  void'(stim_queue.pop_front());
               end
               default: void'(stim_queue.pop_front());
            endcase
         end
         push <= next_push;
      end
   end

   // Monitor: accept counts and score them against the oldest prediction
   always @(posedge clock) begin : monitor
      mrc_pkg::count_type exp_count;
      if (reset) begin
         pop <= 1'b0;
      end else begin
         if (pop && !empty) begin
            if (expected_counts.size() == 0) begin
               $error("converging_count: result with no request outstanding, actual %0d",
                      rsp_converging_count);
               fail_count = fail_count + 1;
            end else begin
               exp_count = expected_counts.pop_front();
               if (rsp_converging_count !== exp_count) begin
                  $error("converging_count mismatch: expected %0d, actual %0d",
                         exp_count, rsp_converging_count);
                  fail_count = fail_count + 1;
               end
            end
            results_retired <= results_retired + 1;
         end
         pop <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Run-length guard
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > cycle_limit) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin : stimulus
      logic [mrc_pkg::ADJ_WIDTH-1:0] graph;
      int                   random_count;
      int                   burst;
      int                   n_raw, lim_raw;
      int                   i;

      queue_control(STIM_PACE, 20, 48);

      // reset settings: 8 nodes, 100 steps
      queue_request('0);
      queue_request('1);
      graph = '0;
      for (i = 0; i < mrc_pkg::NODE_SLOTS; i++)
         graph[i*mrc_pkg::NODE_SLOTS + (i + 1) % mrc_pkg::NODE_SLOTS] = 1'b1; // directed ring
      queue_request(graph);

      // zero node count and zero step limit both act as one
      queue_config(0, 0);
      queue_request('0);
      queue_request('1);
      queue_request(64'h1);                                    // self-loop on node 0

      // oversize node count saturates; longest step limit
      queue_config(15, 255);
      queue_request(64'h8040_2010_0804_0201);                  // self-loops only
      queue_request({$urandom(), $urandom()});

      // two nodes: tied start states, swap graph oscillates to the limit
      queue_config(2, 255);
      queue_request('1);
      queue_request(64'h0102);

      // four nodes: edges touching unused nodes must be ignored
      queue_config(4, 6);
      queue_request(64'hFFFF_FFFF_F0F0_F0F0);
      queue_request(64'h0F0F_0F0F);
      queue_request({$urandom(), $urandom()});

      // random phases; large node counts get short step limits
      random_count = 0;
      while (random_count < 85) begin
         case ($urandom_range(7))
            0: begin
               n_raw = ($urandom_range(1) == 0) ? 0 : $urandom_range(9, 15);
               lim_raw = $urandom_range(0, 3);
            end
            1, 2: begin
               n_raw = $urandom_range(6, 8);
               lim_raw = $urandom_range(1, 8);
            end
            default: begin
               n_raw = $urandom_range(1, 5);
               lim_raw = $urandom_range(1, 255);
            end
         endcase
         queue_config(n_raw, lim_raw);
         burst = $urandom_range(4, 12);
         repeat (burst) begin
            if (random_count == 33) queue_control(STIM_PACE, 48, 20);
            if (random_count == 50) queue_control(STIM_DRAIN, 0, 0);
            if (random_count == 66) queue_control(STIM_PACE, 0, 0);
            case ($urandom_range(3))
               0: graph = {$urandom(), $urandom()};
               1: graph = {$urandom() & $urandom(), $urandom() & $urandom()};
               2: graph = {$urandom() | $urandom(), $urandom() | $urandom()};
               default: graph = {$urandom(), $urandom()} | 64'h8040_2010_0804_0201;
            endcase
            queue_request(graph);
            random_count++;
         end
      end

      cycle_limit = 4 * cycle_budget + 20000;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // wait for the queue to run dry and every count to come back
      @(negedge clock);
      while (stim_queue.size() != 0 || push || psel ||
             requests_accepted != results_retired)
         @(negedge clock);
      repeat (100) @(posedge clock);

      if (expected_counts.size() != 0) begin
         $error("converging_count: %0d expected results never arrived",
                expected_counts.size());
         fail_count = fail_count + 1;
      end
      if (fail_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

/* majority_rule_consensus_counter.f */
hw/rtl/mrc_pkg.sv
hw/rtl/mrc_fifo.sv
hw/rtl/mrc_front.sv
hw/rtl/mrc_engine.sv
hw/rtl/majority_rule_consensus_counter.sv
bench/tb_top.sv
